### rtl/core/itf_pkg.sv
`timescale 1ns / 1ps

package itf_pkg;

  // one conversion request
  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  radix;
    logic [7:0]  min_width;
    logic [7:0]  min_digits;
    logic        flag_signed;
    logic        flag_plus;
    logic        flag_space;
    logic        flag_left;
    logic        flag_zero_pad;
    logic        flag_prefix;
    logic        flag_upper;
  } req_t;

  // one output beat of text
  typedef struct packed {
    logic [63:0] text_beat;
    logic [3:0]  char_count;
    logic        last_beat;
  } res_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP_A,
    ST_PREP_B,
    ST_PREP_C,
    ST_EMIT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic prep_a;
    logic prep_b;
    logic prep_c;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic radix_ok;
    logic div_last;
    logic quo_zero;
    logic emit_last;
  } stat_t;

  // radix limits and the bases that carry a prefix
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_OCT = 6'd8;
  localparam logic [5:0] RADIX_HEX = 6'd16;

  // ascii codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  // digit value 0..35 to its ascii character
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] alpha;
    alpha = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 6'd10) begin
      return CH_ZERO + 8'(d);
    end else begin
      return alpha + 8'(d) - 8'd10;
    end
  endfunction

endpackage

### rtl/core/itf_ctrl.sv
`timescale 1ns / 1ps

module itf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  itf_pkg::stat_t  stat_i,
  output itf_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

  itf_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itf_pkg::ST_IDLE: begin
        if (start_i && stat_i.radix_ok) state_d = itf_pkg::ST_DIV;
      end
      itf_pkg::ST_DIV: begin
        if (stat_i.div_last && stat_i.quo_zero) state_d = itf_pkg::ST_PREP_A;
      end
      itf_pkg::ST_PREP_A: state_d = itf_pkg::ST_PREP_B;
      itf_pkg::ST_PREP_B: state_d = itf_pkg::ST_PREP_C;
      itf_pkg::ST_PREP_C: state_d = itf_pkg::ST_EMIT;
      itf_pkg::ST_EMIT: begin
        if (stat_i.emit_last) state_d = itf_pkg::ST_IDLE;
      end
      default: state_d = itf_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      itf_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      itf_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      itf_pkg::ST_PREP_A: cmd_o.prep_a   = 1'b1;
      itf_pkg::ST_PREP_B: cmd_o.prep_b   = 1'b1;
      itf_pkg::ST_PREP_C: cmd_o.prep_c   = 1'b1;
      itf_pkg::ST_EMIT:   cmd_o.emit     = 1'b1;
      default:            busy_o         = 1'b1;
    endcase
  end

endmodule

### rtl/core/itf_dp.sv
`timescale 1ns / 1ps

module itf_dp #(
  parameter int MAX_WIDTH      = 255,
  parameter int VALUE_BITS     = 64,
  parameter int CHARS_PER_BEAT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  itf_pkg::req_t  req_i,
  input  itf_pkg::cmd_t  cmd_i,
  output itf_pkg::stat_t stat_o,
  output itf_pkg::res_t  res_o,
  output logic           res_valid_o
);

  localparam int DIV_CYC = (VALUE_BITS + 7) / 8;
  localparam int DW      = DIV_CYC * 8;
  localparam int CW      = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int NW      = $clog2(VALUE_BITS + 1);
  localparam int MAXLEN  = ((MAX_WIDTH > VALUE_BITS) ? MAX_WIDTH : VALUE_BITS) + 3;
  localparam int PW      = $clog2(MAXLEN + CHARS_PER_BEAT + 1);
  localparam int LW      = (CHARS_PER_BEAT > 1) ? $clog2(CHARS_PER_BEAT) : 1;
  localparam int KW      = $clog2(CHARS_PER_BEAT + 1);

  // request fields held for the whole conversion
  logic [5:0]    radix_q;
  logic          upper_q, left_q, zpad_q, has_sign_q;
  logic [7:0]    sign_ch_q;
  logic [1:0]    pfx_len_q;
  logic [PW-1:0] width_q, prec_in_q;

  // division state
  logic [DW-1:0] work_q, work_d;
  logic [5:0]    rem_q, rem_d;
  logic [CW-1:0] cyc_q;
  logic [NW-1:0] nd_q;
  logic [5:0]    dig_q [VALUE_BITS];
  logic [5:0]    dig_d [VALUE_BITS];

  // layout of the text
  logic [PW-1:0] used_q, pad_q;
  logic [PW-1:0] b0_q, b1_q, b2_q, b3_q, b4_q, len_q;
  logic [PW-1:0] pos_q;

  // output register
  itf_pkg::res_t res_q, res_d;
  logic          res_valid_q;

  // load-time decode
  logic [VALUE_BITS-1:0] mag_raw, mag_neg;
  logic                  neg;
  logic [1:0]            pfx_len_d;
  logic [PW-1:0]         width_sat, prec_sat;

  always_comb begin
    mag_raw   = req_i.value[VALUE_BITS-1:0];
    mag_neg   = '0 - mag_raw;
    neg       = req_i.flag_signed & mag_raw[VALUE_BITS-1];
    pfx_len_d = 2'd0;
    if (req_i.flag_prefix && req_i.radix == itf_pkg::RADIX_HEX) pfx_len_d = 2'd2;
    else if (req_i.flag_prefix && req_i.radix == itf_pkg::RADIX_OCT) pfx_len_d = 2'd1;
    width_sat = (req_i.min_width > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(req_i.min_width);
    prec_sat  = (req_i.min_digits > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(req_i.min_digits);
  end

  assign stat_o.radix_ok = req_i.radix inside {[itf_pkg::RADIX_MIN:itf_pkg::RADIX_MAX]};

  // eight restoring steps of the radix division per cycle
  logic [5:0] step_r;
  logic [6:0] step_t;
  logic [7:0] step_q;

  always_comb begin
    step_r = rem_q;
    step_q = '0;
    for (int s = 0; s < 8; s++) begin
      step_t = {step_r, work_q[DW-1-s]};
      if (step_t >= {1'b0, radix_q}) begin
        step_t        = step_t - {1'b0, radix_q};
        step_q[7 - s] = 1'b1;
      end
      step_r = step_t[5:0];
    end
    work_d = (work_q << 8) | DW'(step_q);
    rem_d  = step_r;
  end

  assign stat_o.div_last = (cyc_q == CW'(DIV_CYC - 1));
  assign stat_o.quo_zero = (work_d == '0);

  // per-lane character selection for one beat
  logic [PW-1:0] dbase, rem_len;
  logic [PW-1:0] lane_pos [CHARS_PER_BEAT];
  logic [LW-1:0] lane_idx [CHARS_PER_BEAT];
  logic [5:0]    win      [CHARS_PER_BEAT];
  logic [7:0]    lane_ch  [CHARS_PER_BEAT];
  logic          lane_vld [CHARS_PER_BEAT];
  logic          lane_dig [CHARS_PER_BEAT];
  logic [KW-1:0] ndig, cnt;
  logic [63:0]   beat;
  logic          beat_last;

  always_comb begin
    dbase   = (pos_q > b3_q) ? pos_q : b3_q;
    rem_len = len_q - pos_q;
    ndig    = '0;
    beat    = '0;
    for (int k = 0; k < CHARS_PER_BEAT; k++) begin
      win[k]      = dig_q[k];
      lane_pos[k] = pos_q + PW'(k);
      lane_vld[k] = lane_pos[k] < len_q;
      lane_dig[k] = lane_vld[k] && lane_pos[k] >= b3_q && lane_pos[k] < b4_q;
      lane_idx[k] = LW'(lane_pos[k] - dbase);
      if (lane_pos[k] < b0_q) begin
        lane_ch[k] = itf_pkg::CH_SPACE;
      end else if (lane_pos[k] < b1_q) begin
        lane_ch[k] = sign_ch_q;
      end else if (lane_pos[k] < b2_q) begin
        if (lane_pos[k] == b1_q) lane_ch[k] = itf_pkg::CH_ZERO;
        else lane_ch[k] = upper_q ? itf_pkg::CH_UPPER_X : itf_pkg::CH_LOWER_X;
      end else if (lane_pos[k] < b3_q) begin
        lane_ch[k] = itf_pkg::CH_ZERO;
      end else if (lane_pos[k] < b4_q) begin
        lane_ch[k] = itf_pkg::digit_char(win[lane_idx[k]], upper_q);
      end else begin
        lane_ch[k] = itf_pkg::CH_SPACE;
      end
      if (lane_vld[k]) beat[8*k +: 8] = lane_ch[k];
      ndig = ndig + KW'(lane_dig[k]);
    end
    beat_last = rem_len <= PW'(CHARS_PER_BEAT);
    cnt       = beat_last ? KW'(rem_len) : KW'(CHARS_PER_BEAT);
  end

  assign stat_o.emit_last = beat_last;

  // digit shift line: push at the end of a division, drop consumed digits on emit
  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      dig_d[i] = dig_q[i];
    end
    if (cmd_i.div_step && stat_o.div_last) begin
      dig_d[0] = rem_d;
      for (int i = 1; i < VALUE_BITS; i++) begin
        dig_d[i] = dig_q[i-1];
      end
    end else if (cmd_i.emit) begin
      for (int i = 0; i < VALUE_BITS; i++) begin
        for (int a = 1; a <= CHARS_PER_BEAT; a++) begin
          if (ndig == KW'(a)) begin
            if (i + a < VALUE_BITS) dig_d[i] = dig_q[i+a];
            else dig_d[i] = '0;
          end
        end
      end
    end
  end

  // output beat
  always_comb begin
    res_d            = res_q;
    res_d.text_beat  = beat;
    res_d.char_count = 4'(cnt);
    res_d.last_beat  = beat_last;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_q       <= '0;
      nd_q        <= '0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        cyc_q <= '0;
        nd_q  <= '0;
      end else if (cmd_i.div_step) begin
        if (stat_o.div_last) begin
          cyc_q <= '0;
          nd_q  <= nd_q + NW'(1);
        end else begin
          cyc_q <= cyc_q + CW'(1);
        end
      end
      if (cmd_i.prep_c) pos_q <= '0;
      else if (cmd_i.emit) pos_q <= pos_q + PW'(CHARS_PER_BEAT);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q    <= req_i.radix;
      upper_q    <= req_i.flag_upper;
      left_q     <= req_i.flag_left;
      zpad_q     <= req_i.flag_zero_pad & ~req_i.flag_left;
      has_sign_q <= req_i.flag_signed & (neg | req_i.flag_plus | req_i.flag_space);
      sign_ch_q  <= neg ? itf_pkg::CH_MINUS
                  : (req_i.flag_plus ? itf_pkg::CH_PLUS : itf_pkg::CH_SPACE);
      pfx_len_q  <= pfx_len_d;
      width_q    <= width_sat;
      prec_in_q  <= prec_sat;
      work_q     <= neg ? DW'(mag_neg) : DW'(mag_raw);
      rem_q      <= '0;
    end else if (cmd_i.div_step) begin
      work_q <= work_d;
      rem_q  <= stat_o.div_last ? '0 : rem_d;
    end
    if (cmd_i.prep_a) begin
      used_q <= ((prec_in_q > PW'(nd_q)) ? prec_in_q : PW'(nd_q))
              + PW'(has_sign_q) + PW'(pfx_len_q);
    end
    if (cmd_i.prep_b) begin
      pad_q <= (width_q > used_q) ? width_q - used_q : '0;
    end
    if (cmd_i.prep_c) begin
      b0_q  <= (!left_q && !zpad_q) ? pad_q : '0;
      b1_q  <= ((!left_q && !zpad_q) ? pad_q : '0) + PW'(has_sign_q);
      b2_q  <= ((!left_q && !zpad_q) ? pad_q : '0) + PW'(has_sign_q) + PW'(pfx_len_q);
      b3_q  <= (left_q ? used_q : used_q + pad_q) - PW'(nd_q);
      b4_q  <= left_q ? used_q : used_q + pad_q;
      len_q <= used_q + pad_q;
    end
    if (cmd_i.emit) res_q <= res_d;
    for (int i = 0; i < VALUE_BITS; i++) begin
      dig_q[i] <= dig_d[i];
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

### rtl/core/integer_to_text_formatter.sv
`timescale 1ns / 1ps

// channel   ports                      direction  transfer
// request   start_i, busy_o, req_i     in         start_i high while busy_o low
// result    res_valid_o, res_o         out        back to back beats, no stall
//
// each request divides by the radix once per digit in the shared radix
// divider (one digit for a zero value), then runs three layout steps, then
// emits one beat of CHARS_PER_BEAT characters per cycle.
// the last beat is on res_o in the first cycle with busy_o low; a new request may start then.
// reset is asynchronous active low and returns the controller to idle.
// the receiver cannot stall: beats of one request come on consecutive cycles.

module integer_to_text_formatter #(
  parameter int MAX_WIDTH      = 255,
  parameter int VALUE_BITS     = 64,
  parameter int CHARS_PER_BEAT = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  itf_pkg::req_t req_i,
  output logic          res_valid_o,
  output itf_pkg::res_t res_o
);

  itf_pkg::cmd_t  cmd;
  itf_pkg::stat_t stat;

  // sequencer
  itf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // divider, layout and beat packer
  itf_dp #(
    .MAX_WIDTH      (MAX_WIDTH),
    .VALUE_BITS     (VALUE_BITS),
    .CHARS_PER_BEAT (CHARS_PER_BEAT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // beat sizes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.char_count != 4'd0 && res_o.char_count <= CHARS_PER_BEAT))
    else $error("beat character count out of range");

  // only the final beat may be short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_beat) |-> (res_o.char_count == CHARS_PER_BEAT))
    else $error("short beat before the end of the text");

  // a text never breaks off before its last beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_beat) |=> res_valid_o)
    else $error("gap inside a text");

  // a request with a legal radix starts a conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.radix >= itf_pkg::RADIX_MIN &&
     req_i.radix <= itf_pkg::RADIX_MAX) |=> busy_o)
    else $error("request with legal radix not taken up");

endmodule
